/* src/slrg_pkg.sv */
// slrg_pkg: shared widths, parameter defaults, reset values, register indexes
// and operation codes of the linear ramp step generator. No dependencies.
package slrg_pkg;

	localparam int unsigned IVL_W      = 24;
	localparam int unsigned ACC_W      = 16;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned STEPS_W    = 32;
	localparam int unsigned TGT_W      = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam int unsigned DEF_FRAC_BITS     = 8;
	localparam int unsigned DEF_POSITION_BITS = 32;

	localparam logic [IVL_W-1:0] RST_START_IVL = 24'd256000;
	localparam logic [IVL_W-1:0] RST_MIN_IVL   = 24'd12800;
	localparam logic [IVL_W-1:0] RST_IVL_STEP  = 24'd12160;
	localparam logic [ACC_W-1:0] RST_ACCEL     = 16'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_INTERVAL = 2'd0,
		REG_MIN_INTERVAL   = 2'd1,
		REG_INTERVAL_STEP  = 2'd2,
		REG_ACCEL_STEPS    = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_MOVE = 1'b1
	} op_t;

endpackage

/* src/slrg_if.sv */
// slrg channel interfaces: command, result and register write channels.
// Depends on slrg_pkg.
interface slrg_cmd_if;
	logic                             valid;
	logic                             ready;
	logic                             operation;
	logic signed [slrg_pkg::TGT_W-1:0] target_position;
	modport source (output valid, operation, target_position, input ready);
	modport sink (input valid, operation, target_position, output ready);
endinterface

interface slrg_res_if;
	logic                               valid;
	logic                               ready;
	logic                               step_pulse;
	logic                               forward;
	logic signed [slrg_pkg::TGT_W-1:0]  position;
	logic        [slrg_pkg::IVL_W-1:0]  interval_now;
	logic                               busy_res;
	modport source (output valid, step_pulse, forward, position, interval_now, busy_res,
		input ready);
	modport sink (input valid, step_pulse, forward, position, interval_now, busy_res,
		output ready);
endinterface

interface slrg_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [slrg_pkg::CFG_IDX_W-1:0]      index;
	logic [slrg_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/stepper_linear_ramp_generator_unit.sv */
// Trapezoidal stepper ramp generator, top level.
// Depends on slrg_pkg and the channel interfaces in slrg_if.sv.
//
// Usage:
//   cmd carries one item per beat: a tick (operation 0) or a move start
//   (operation 1, with target_position). Every command beat yields exactly one
//   res beat: step flag, direction, position, current interval, busy flag.
//   cfg writes the four ramp registers (start interval, minimum interval,
//   interval step, ramp steps); it is always ready and is meant to be used
//   while no command is in flight.
// Path: a cmd beat passes the input register, then the result register,
//   which is loaded together with the motion state.
// Throughput: one item per cycle while res is not held, set by the update
//   of the position, step count and interval registers.
// Reset: motion state clears to idle at position zero, registers take their
//   defaults, both pipeline registers empty.
// Stall: while res is held, the result register keeps its beat and the input
//   register can still take one more command; cmd ready then drops until the
//   result is taken.
module stepper_linear_ramp_generator_unit #(
	parameter int unsigned INTERVAL_FRAC_BITS = slrg_pkg::DEF_FRAC_BITS,
	parameter int unsigned POSITION_BITS      = slrg_pkg::DEF_POSITION_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	slrg_cfg_if.sink     cfg,
	slrg_cmd_if.sink     cmd,
	slrg_res_if.source   res
);
	import slrg_pkg::*;

	localparam int unsigned DW = POSITION_BITS + 1;
	localparam int unsigned MW = (DW > STEPS_W + 1) ? DW : STEPS_W + 1;
	localparam int unsigned XW = (POSITION_BITS > TGT_W) ? POSITION_BITS : TGT_W;
	localparam int unsigned CW = (CNT_W + INTERVAL_FRAC_BITS > IVL_W) ?
		CNT_W + INTERVAL_FRAC_BITS : IVL_W;

	// configuration
	logic [IVL_W-1:0] start_ivl_q, min_ivl_q, ivl_step_q;
	logic [ACC_W-1:0] accel_q;

	// input stage
	logic                    vld_s1;
	logic                    op_s1;
	logic signed [TGT_W-1:0] tgt_s1;

	// motion state
	logic signed [POSITION_BITS-1:0] pos_q;
	logic [STEPS_W-1:0]              steps_q;
	logic                            fwd_q;
	logic [IVL_W-1:0]                ivl_q;
	logic [ACC_W-1:0]                ramp_q;
	logic [CNT_W-1:0]                cnt_q;

	// result register
	logic                    out_vld_q;
	logic                    pulse_q;
	logic                    fwd_out_q;
	logic signed [TGT_W-1:0] pos_out_q;
	logic [IVL_W-1:0]        ivl_out_q;
	logic                    busy_q;

	logic advance;

	// next-state values
	logic signed [POSITION_BITS-1:0] pos_d;
	logic [STEPS_W-1:0]              steps_d;
	logic                            fwd_d;
	logic [IVL_W-1:0]                ivl_d;
	logic [ACC_W-1:0]                ramp_d;
	logic [CNT_W-1:0]                cnt_d;
	logic                            pulse_d;

	// move decode
	logic signed [XW-1:0]            tgt_x;
	logic signed [POSITION_BITS-1:0] tgt_p;
	logic signed [DW-1:0]            diff;
	logic [DW-1:0]                   mag;
	logic [MW-1:0]                   mag_x;
	logic [STEPS_W-1:0]              dist_sat;
	logic [STEPS_W-1:0]              half;

	// tick decode
	logic [CNT_W-1:0]     cnt_inc;
	logic [CW-1:0]        cnt_fx;
	logic [CW-1:0]        ivl_fx;
	logic [STEPS_W-1:0]   steps_dec;
	logic [IVL_W:0]       ivl_sum;
	logic signed [XW-1:0] pos_x;

	assign advance   = vld_s1 && (!out_vld_q || res.ready);
	assign cmd.ready = !vld_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_ivl_q <= RST_START_IVL;
			min_ivl_q   <= RST_MIN_IVL;
			ivl_step_q  <= RST_IVL_STEP;
			accel_q     <= RST_ACCEL;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_START_INTERVAL: start_ivl_q <= cfg.data[IVL_W-1:0];
				REG_MIN_INTERVAL:   min_ivl_q   <= cfg.data[IVL_W-1:0];
				REG_INTERVAL_STEP:  ivl_step_q  <= cfg.data[IVL_W-1:0];
				REG_ACCEL_STEPS:    accel_q     <= cfg.data[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1  <= cmd.operation;
			tgt_s1 <= cmd.target_position;
		end
	end

	always_comb begin
		tgt_x    = XW'(tgt_s1);
		tgt_p    = tgt_x[POSITION_BITS-1:0];
		diff     = DW'(tgt_p) - DW'(pos_q);
		mag      = diff[DW-1] ? DW'(-diff) : DW'(diff);
		mag_x    = MW'(mag);
		dist_sat = (|mag_x[MW-1:STEPS_W]) ? {STEPS_W{1'b1}} : mag_x[STEPS_W-1:0];
		half     = dist_sat >> 1;

		cnt_inc   = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
		cnt_fx    = CW'({cnt_inc, {INTERVAL_FRAC_BITS{1'b0}}});
		ivl_fx    = CW'(ivl_q);
		steps_dec = steps_q - 1'b1;
		ivl_sum   = {1'b0, ivl_q} + {1'b0, ivl_step_q};

		pos_d   = pos_q;
		steps_d = steps_q;
		fwd_d   = fwd_q;
		ivl_d   = ivl_q;
		ramp_d  = ramp_q;
		cnt_d   = cnt_q;
		pulse_d = 1'b0;

		if (op_t'(op_s1) == OP_MOVE) begin
			fwd_d   = (diff > 0);
			steps_d = dist_sat;
			ramp_d  = (STEPS_W'(accel_q) < half) ? accel_q : half[ACC_W-1:0];
			ivl_d   = (dist_sat != '0) ? start_ivl_q : '0;
			cnt_d   = '0;
		end else if (steps_q != '0) begin
			cnt_d = cnt_inc;
			if (cnt_fx >= ivl_fx) begin
				pulse_d = 1'b1;
				pos_d   = fwd_q ? pos_q + 1'b1 : pos_q - 1'b1;
				cnt_d   = '0;
				steps_d = steps_dec;
				priority if (steps_dec == '0) begin
					ivl_d = '0;
				end else if (steps_dec >= STEPS_W'(ramp_q) &&
						ivl_q[IVL_W-1:INTERVAL_FRAC_BITS] > min_ivl_q[IVL_W-1:INTERVAL_FRAC_BITS]) begin
					ivl_d = (ivl_q > ivl_step_q) ? ivl_q - ivl_step_q : '0;
				end else if (steps_dec <= STEPS_W'(ramp_q)) begin
					ivl_d = ivl_sum[IVL_W] ? {IVL_W{1'b1}} : ivl_sum[IVL_W-1:0];
				end else begin
					ivl_d = ivl_q;
				end
			end
		end

		pos_x = XW'(pos_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			steps_q   <= '0;
			fwd_q     <= 1'b0;
			ivl_q     <= '0;
			ramp_q    <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q   <= pos_d;
				steps_q <= steps_d;
				fwd_q   <= fwd_d;
				ivl_q   <= ivl_d;
				ramp_q  <= ramp_d;
				cnt_q   <= cnt_d;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q   <= pulse_d;
			fwd_out_q <= fwd_d;
			pos_out_q <= pos_x[TGT_W-1:0];
			ivl_out_q <= ivl_d;
			busy_q    <= (steps_d != '0);
		end
	end

	assign res.valid        = out_vld_q;
	assign res.step_pulse   = pulse_q;
	assign res.forward      = fwd_out_q;
	assign res.position     = pos_out_q;
	assign res.interval_now = ivl_out_q;
	assign res.busy_res     = busy_q;

endmodule
